[hdl/bpe_pkg.sv]
package bpe_pkg;

    localparam int FRAC = 16;

    localparam logic [1:0] ACT_LOAD_U = 2'd0;
    localparam logic [1:0] ACT_LOAD_V = 2'd1;
    localparam logic [1:0] ACT_LOAD_P = 2'd2;
    localparam logic [1:0] ACT_EVAL   = 2'd3;

    localparam logic [1:0] REG_TESS_U = 2'd0;
    localparam logic [1:0] REG_TESS_V = 2'd1;
    localparam logic [1:0] REG_COMP   = 2'd2;

    typedef struct packed {
        logic [1:0]         action;
        logic [3:0]         slot;
        logic signed [31:0] in_x;
        logic signed [31:0] in_y;
        logic signed [31:0] in_z;
        logic signed [31:0] in_w;
        logic [8:0]         u_step;
        logic [8:0]         v_step;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [31:0] out_w;
    } out_word_t;

    // saturate a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [71:0] x);
        if (x > 72'sd2147483647)
            return 32'sh7fffffff;
        else if (x < -72'sd2147483648)
            return 32'sh80000000;
        else
            return x[31:0];
    endfunction

endpackage

[hdl/bpe_div.sv]
// restoring divider, one quotient bit per cycle: q = floor(num / den)
module bpe_div
    import bpe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [25:0] num,
    input  logic [8:0]  den,
    output logic        busy,
    output logic [25:0] quo
);
    logic [25:0] quo_reg, quo_next;
    logic [9:0]  rem_reg, rem_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [8:0]  den_reg, den_next;
    logic [10:0] trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        den_next  = den_reg;
        trial     = {rem_reg, quo_reg[25]};
        if (start)
        begin
            quo_next  = num;
            rem_next  = '0;
            cnt_next  = 5'd0;
            busy_next = 1'b1;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            if (trial >= {2'b0, den_reg})
            begin
                rem_next = 10'(trial - {2'b0, den_reg});
                quo_next = {quo_reg[24:0], 1'b1};
            end
            else
            begin
                rem_next = trial[9:0];
                quo_next = {quo_reg[24:0], 1'b0};
            end
            cnt_next = 5'(cnt_reg + 5'd1);
            if (cnt_reg == 5'd25)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;
endmodule

[hdl/bpe_mac.sv]
// shared multiplier: one 33x33 signed product per cycle, registered
module bpe_mac
    import bpe_pkg::*;
(
    input  logic               clk,
    input  logic signed [32:0] a,
    input  logic signed [32:0] b,
    output logic signed [65:0] prod
);
    logic signed [65:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;
endmodule

[hdl/bicubic_patch_evaluate.sv]
// bicubic patch evaluator with loadable basis matrices
// in channel (in_valid/in_ready, in_data): one word per action; load u basis,
//   load v basis and load control point give no result;
//   evaluate gives exactly one out word
// cfg channel (cfg_valid/cfg_ready, cfg_index/cfg_data): tess_u, tess_v,
//   comp_count; always ready, write only while idle
// out channel (out_valid/out_ready, out_data): one result word held in a
//   register until taken
// evaluate: two divisions on the shared divider, then the shared multiplier
//   runs t^2 and t^3, 32 weight terms, and for each of four components four
//   inner column sums and an outer sum; the done state then loads the out
//   register
// the block takes no new word while an evaluate runs or its result waits
// reset: basis words clear to zero, tess 1/1, comp_count 3, out channel empty
// a stalled receiver just holds out_valid and the block waits
module bicubic_patch_evaluate
    import bpe_pkg::*;
#(
    parameter int MAX_TESS = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_word_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_word_t   out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DIVU  = 4'd1;
    localparam logic [3:0] S_DIVV  = 4'd2;
    localparam logic [3:0] S_POW   = 4'd3;
    localparam logic [3:0] S_WGT   = 4'd4;
    localparam logic [3:0] S_INNER = 4'd5;
    localparam logic [3:0] S_OUTER = 4'd6;
    localparam logic [3:0] S_DONE  = 4'd7;
    localparam logic [3:0] S_WAIT  = 4'd8;

    localparam logic signed [32:0] HALF = 33'sd1 <<< (FRAC - 1);

    logic [3:0]  state_reg, state_next;
    logic [8:0]  tess_u_reg, tess_v_reg;
    logic [2:0]  comp_reg;
    logic signed [31:0] ub_reg [16];
    logic signed [31:0] vb_reg [16];
    logic [127:0] cp_mem [16];
    logic [127:0] cp_rd;
    logic [8:0]  vs_reg;
    logic [16:0] tu_reg;
    logic signed [32:0] pw_reg [2][3];   // t, t2, t3 for u and v
    logic signed [31:0] w_reg [2][4];    // weights u, v
    logic signed [31:0] inner_reg [4];
    logic signed [31:0] res_reg [4];
    logic signed [71:0] acc_reg;
    logic [5:0]  k_reg;                  // step counter inside a phase
    logic [1:0]  comp_i_reg;             // current component
    logic [1:0]  col_reg;                // current inner column
    logic        issue_reg;              // product issued last cycle
    logic        last_reg;
    out_word_t   out_reg;
    logic        out_valid_reg;

    logic [8:0]  eff_tu, eff_tv, step_c;
    logic        div_start, div_busy;
    logic [25:0] div_num, div_quo;
    logic [8:0]  div_den;
    logic signed [32:0] ma, mb;
    logic signed [65:0] prod;
    logic signed [71:0] rounded;

    bpe_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num),
        .den(div_den), .busy(div_busy), .quo(div_quo)
    );

    bpe_mac u_mac (.clk(clk), .a(ma), .b(mb), .prod(prod));

    function automatic logic [8:0] eff(input logic [8:0] r);
        if (r == 9'd0)
            return 9'd1;
        else if (32'(r) > MAX_TESS)
            return 9'(MAX_TESS);
        else
            return r;
    endfunction

    assign eff_tu = eff(tess_u_reg);
    assign eff_tv = eff(tess_v_reg);

    logic [2:0] cc;
    assign cc = (comp_reg == 3'd0) ? 3'd1 : ((comp_reg > 3'd4) ? 3'd4 : comp_reg);

    // divider operand: (step << FRAC) + tess/2 over tess
    logic [8:0] dten;
    assign dten   = (state_reg == S_IDLE) ? eff_tu : eff_tv;
    assign step_c = (state_reg == S_IDLE) ? ((in_data.u_step > eff_tu) ? eff_tu : in_data.u_step)
                                          : ((vs_reg > eff_tv) ? eff_tv : vs_reg);
    assign div_num = {step_c, 17'd0} >> 1 | 26'(dten >> 1);
    assign div_den = dten;
    assign div_start = (state_reg == S_IDLE && in_valid && in_data.action == ACT_EVAL)
                    || (state_reg == S_DIVU && !div_busy && issue_reg);

    // operand selection for the shared multiplier
    logic [1:0] kk;          // term or row within a group of four
    logic [1:0] kg;          // group (weight or column index)
    logic       side;
    assign kk = k_reg[1:0];
    assign kg = k_reg[3:2];
    assign side = k_reg[4];
    logic signed [31:0] cpv;
    always_comb
    begin
        unique case (comp_i_reg)
            2'd0: cpv = cp_rd[127:96];
            2'd1: cpv = cp_rd[95:64];
            2'd2: cpv = cp_rd[63:32];
            default: cpv = cp_rd[31:0];
        endcase
    end

    always_comb
    begin
        ma = '0;
        mb = '0;
        unique case (state_reg)
            S_POW:
            begin
                // k: 0 t2u, 1 t2v, 2 t3u, 3 t3v
                ma = pw_reg[k_reg[0]][0];
                mb = (k_reg[1]) ? pw_reg[k_reg[0]][1] : pw_reg[k_reg[0]][0];
            end
            S_WGT:
            begin
                if (kk == 2'd3)
                    ma = 33'sd1 <<< FRAC;
                else
                    ma = pw_reg[side][2'd2 - kk];
                mb = side ? 33'(vb_reg[{kk, kg}]) : 33'(ub_reg[{kk, kg}]);
            end
            S_INNER:
            begin
                // point data of row k-1 is on cp_rd now
                ma = 33'(w_reg[1][2'(kk - 2'd1)]);
                mb = 33'(cpv);
            end
            S_OUTER:
            begin
                ma = 33'(w_reg[0][kk]);
                mb = 33'(inner_reg[kk]);
            end
            default:
            begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    assign rounded = (acc_reg + 72'(prod) + 72'(HALF)) >>> FRAC;

    // control point read address: row kk of column col
    logic [3:0] cp_addr;
    assign cp_addr = {k_reg[1:0], col_reg};
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready && in_data.action == ACT_LOAD_P)
            cp_mem[in_data.slot] <= {in_data.in_x, in_data.in_y, in_data.in_z, in_data.in_w};
        cp_rd <= cp_mem[cp_addr];
    end

    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tess_u_reg    <= 9'd1;
            tess_v_reg    <= 9'd1;
            comp_reg      <= 3'd3;
            out_valid_reg <= 1'b0;
            k_reg         <= '0;
            issue_reg     <= 1'b0;
            comp_i_reg    <= '0;
            col_reg       <= '0;
            last_reg      <= 1'b0;
            for (int i = 0; i < 16; i++)
            begin
                ub_reg[i] <= '0;
                vb_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_TESS_U: tess_u_reg <= cfg_data[8:0];
                    REG_TESS_V: tess_v_reg <= cfg_data[8:0];
                    REG_COMP:   comp_reg   <= cfg_data[2:0];
                    default:    ;
                endcase
            end
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        unique case (in_data.action)
                            ACT_LOAD_U: ub_reg[in_data.slot] <= in_data.in_x;
                            ACT_LOAD_V: vb_reg[in_data.slot] <= in_data.in_x;
                            ACT_LOAD_P: ;
                            default:
                            begin
                                vs_reg    <= in_data.v_step;
                                issue_reg <= 1'b1;
                                state_reg <= S_DIVU;
                            end
                        endcase
                    end
                end
                S_DIVU:
                begin
                    // issue_reg marks the divider as already started
                    if (!div_busy && issue_reg)
                    begin
                        tu_reg    <= div_quo[16:0];
                        state_reg <= S_DIVV;
                    end
                end
                S_DIVV:
                begin
                    if (!div_busy)
                    begin
                        pw_reg[0][0] <= {16'd0, tu_reg};
                        pw_reg[1][0] <= {16'd0, div_quo[16:0]};
                        k_reg        <= '0;
                        issue_reg    <= 1'b0;
                        state_reg    <= S_POW;
                    end
                end
                S_POW:
                begin
                    // results land the cycle after issue; t3 needs t2 first
                    last_reg <= k_reg[0];
                    if (issue_reg)
                    begin
                        pw_reg[last_reg][k_reg[1] ? 2'd2 : 2'd1] <=
                            33'((prod + 66'(HALF)) >>> FRAC);
                        issue_reg <= 1'b0;
                        if (k_reg == 6'd3)
                        begin
                            k_reg     <= '0;
                            acc_reg   <= '0;
                            state_reg <= S_WGT;
                        end
                        else
                            k_reg <= 6'(k_reg + 6'd1);
                    end
                    else
                        issue_reg <= 1'b1;
                end
                S_WGT:
                begin
                    // one term a cycle, product lands next cycle
                    if (issue_reg && k_reg[1:0] == 2'd0)
                    begin
                        w_reg[last_reg][col_reg] <= sat32(rounded);
                        acc_reg <= '0;
                    end
                    else if (issue_reg)
                        acc_reg <= acc_reg + 72'(prod);
                    last_reg <= side;
                    if (k_reg == 6'd32)
                    begin
                        k_reg      <= '0;
                        issue_reg  <= 1'b0;
                        comp_i_reg <= '0;
                        col_reg    <= '0;
                        state_reg  <= S_INNER;
                    end
                    else
                    begin
                        k_reg     <= 6'(k_reg + 6'd1);
                        issue_reg <= 1'b1;
                        col_reg   <= kg;
                    end
                end
                S_INNER:
                begin
                    // address from k, then data registered on cp_rd, then product in the multiplier register
                    if (k_reg == 6'd5)
                    begin
                        inner_reg[col_reg] <= sat32(rounded);
                        acc_reg <= '0;
                        k_reg   <= '0;
                        col_reg <= 2'(col_reg + 2'd1);
                        if (col_reg == 2'd3)
                            state_reg <= S_OUTER;
                    end
                    else
                    begin
                        k_reg <= 6'(k_reg + 6'd1);
                        if (k_reg >= 6'd2)
                            acc_reg <= acc_reg + 72'(prod);
                    end
                end
                S_OUTER:
                begin
                    if (k_reg == 6'd4)
                    begin
                        res_reg[comp_i_reg] <= ({1'b0, comp_i_reg} < cc) ?
                                               sat32(rounded) : 32'sd0;
                        acc_reg <= '0;
                        k_reg   <= '0;
                        comp_i_reg <= 2'(comp_i_reg + 2'd1);
                        state_reg  <= (comp_i_reg == 2'd3) ? S_DONE : S_INNER;
                    end
                    else
                    begin
                        k_reg <= 6'(k_reg + 6'd1);
                        if (k_reg >= 6'd1)
                            acc_reg <= acc_reg + 72'(prod);
                    end
                end
                S_DONE:
                begin
                    out_reg.out_x <= res_reg[0];
                    out_reg.out_y <= res_reg[1];
                    out_reg.out_z <= res_reg[2];
                    out_reg.out_w <= res_reg[3];
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_WAIT;
                end
                default:
                begin
                    if (!out_valid_reg)
                        state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // an out word waiting blocks the input side
    a_no_accept_with_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("input taken while result waits");

    // an evaluate leaves idle on the next cycle
    a_eval_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_data.action == ACT_EVAL) |=> state_reg == S_DIVU)
        else $error("evaluate not started");

    // the result register is loaded only from the done state
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg) == S_DONE)
        else $error("result without done");
endmodule
